// ===== sv/aes_pkg.sv =====
// AES shared types, S-box tables and GF(2^8) helpers.
// No dependencies; used by the key expander, the round unit and the top level.
package aes_pkg;

  typedef logic [0:255][7:0] sbox_t;
  typedef logic [0:15][7:0]  state_t;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  localparam logic [7:0] GF_POLY = 8'h1b;
  localparam logic [7:0] RCON_INIT = 8'h01;

  localparam sbox_t SBOX = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic sbox_t invert_table(input sbox_t fwd);
    sbox_t inv;
    inv = '0;
    for (int k = 0; k < 256; k++) begin
      inv[fwd[k]] = 8'(k);
    end
    return inv;
  endfunction

  localparam sbox_t INV_SBOX = invert_table(SBOX);

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

// ===== sv/aes_key_expand.sv =====
// AES key schedule expander: one 32-bit round-key word per cycle.
// Depends on aes_pkg for the S-box and xtime.
module aes_key_expand #(
  parameter int KEY_WORDS = 4,
  parameter int ROUNDS    = 10,
  parameter int IW        = $clog2(4 * (ROUNDS + 1))
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [0:3][63:0]    key_i,
  output logic                wr_en_o,
  output logic [IW-1:0]       wr_idx_o,
  output logic [31:0]         wr_word_o,
  output logic                done_o
);
  import aes_pkg::*;

  localparam int RK_DEPTH = 4 * (ROUNDS + 1);
  localparam int MW       = $clog2(KEY_WORDS);

  logic                      busy_q;
  logic [IW-1:0]             idx_q;
  logic [MW-1:0]             mod_q;
  logic [7:0]                rcon_q;
  logic [KEY_WORDS-1:0][31:0] win_q;

  logic [0:7][31:0] key_words;
  logic [31:0]      tmp;
  logic [31:0]      word;
  logic             from_key;
  logic             rot_step;

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  assign key_words = key_i;
  assign from_key  = idx_q < IW'(KEY_WORDS);
  assign rot_step  = !from_key && (mod_q == '0);

  always_comb begin
    tmp = win_q[KEY_WORDS-1];
    if (mod_q == '0) begin
      tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_q, 24'h000000};
    end else if (KEY_WORDS > 6 && int'(mod_q) == 4) begin
      tmp = sub_word(tmp);
    end
    word = from_key ? key_words[idx_q[2:0]] : (win_q[0] ^ tmp);
  end

  assign wr_en_o   = busy_q;
  assign wr_idx_o  = idx_q;
  assign wr_word_o = word;
  assign done_o    = busy_q && (idx_q == IW'(RK_DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      mod_q  <= '0;
      rcon_q <= RCON_INIT;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      mod_q  <= '0;
      rcon_q <= RCON_INIT;
    end else if (busy_q) begin
      if (done_o) begin
        busy_q <= 1'b0;
      end
      idx_q <= idx_q + IW'(1);
      mod_q <= (mod_q == MW'(KEY_WORDS - 1)) ? '0 : mod_q + MW'(1);
      if (rot_step) begin
        rcon_q <= xtime(rcon_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      for (int j = 0; j < KEY_WORDS - 1; j++) begin
        win_q[j] <= win_q[j+1];
      end
      win_q[KEY_WORDS-1] <= word;
    end
  end

endmodule

// ===== sv/aes_round.sv =====
// AES round unit, shared by every round of encrypt and decrypt.
// Depends on aes_pkg for the state type, S-box tables and xtime.
module aes_round (
  input  aes_pkg::state_t st_i,
  input  aes_pkg::state_t rk_i,
  input  logic            dec_i,
  input  logic            first_i,
  input  logic            last_i,
  output aes_pkg::state_t st_o
);
  import aes_pkg::*;

  state_t sr;
  state_t isb;
  state_t mx;
  state_t imx;
  state_t dk;

  function automatic logic [7:0] mul3(input logic [7:0] a);
    return xtime(a) ^ a;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ a;
  endfunction

  function automatic logic [7:0] mulb(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
  endfunction

  function automatic logic [7:0] muld(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
  endfunction

  function automatic logic [7:0] mule(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
  endfunction

  // sub+shift forward, inv-shift+inv-sub backward
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[4*c+r]  = SBOX[st_i[4*((c + r) & 3) + r]];
        isb[4*c+r] = INV_SBOX[st_i[4*((c - r + 4) & 3) + r]];
      end
    end
  end

  assign dk = isb ^ rk_i;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mx[4*c+r] = xtime(sr[4*c+r]) ^ mul3(sr[4*c+((r+1)&3)]) ^
                    sr[4*c+((r+2)&3)] ^ sr[4*c+((r+3)&3)];
        imx[4*c+r] = mule(dk[4*c+r]) ^ mulb(dk[4*c+((r+1)&3)]) ^
                     muld(dk[4*c+((r+2)&3)]) ^ mul9(dk[4*c+((r+3)&3)]);
      end
    end
  end

  always_comb begin
    if (first_i) begin
      st_o = st_i ^ rk_i;
    end else if (dec_i) begin
      st_o = last_i ? dk : imx;
    end else begin
      st_o = (last_i ? sr : mx) ^ rk_i;
    end
  end

endmodule

// ===== sv/aes_block_cipher.sv =====
// AES block cipher top level: key registers, round-key store and round sequencer.
// Depends on aes_pkg, aes_key_expand and aes_round.
//
// One 128-bit block is encrypted or decrypted per input beat, in these steps: a read
// of the first round-key row, ROUNDS+1 passes through the single round unit, a move
// into the output register once that register is free, and the result on the output.
// The next input beat can land on the same edge as the earliest result beat. The
// round-key store is read one 128-bit row per cycle, which sets the one-round-per-cycle
// pace. After reset or any key register write, the next block first runs the key
// schedule, one word per cycle, before its first round-key read. Input ready is low while
// a block is in flight; a finished result waits in the output register while the next
// block is taken.
module aes_block_cipher #(
  parameter int KEY_WORDS = 4,
  parameter int ROUNDS    = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [63:0] block_upper_i,
  input  logic [63:0] block_lower_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_upper_o,
  output logic [63:0] out_lower_o
);
  import aes_pkg::*;

  localparam int ROWS = ROUNDS + 1;
  localparam int IW   = $clog2(4 * ROWS);
  localparam int RW   = $clog2(ROWS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_FINISH
  } state_e;

  state_e           state_q, state_d;
  logic [RW-1:0]    rnd_q, rnd_d;
  logic             stale_q, stale_d;
  logic             dec_q, dec_d;
  state_t           blk_q, blk_d;
  logic [127:0]     out_q, out_d;
  logic             outv_q, outv_d;
  logic [0:3][63:0] key_q;

  logic [31:0]      rk_mem [ROWS][4];
  state_t           rk_q;

  logic             exp_start;
  logic             exp_we;
  logic [IW-1:0]    exp_idx;
  logic [31:0]      exp_word;
  logic             exp_done;

  logic             rd_en;
  logic [RW-1:0]    rd_row;
  logic [RW-1:0]    rnd_nxt;
  state_t           round_out;

  aes_key_expand #(
    .KEY_WORDS (KEY_WORDS),
    .ROUNDS    (ROUNDS),
    .IW        (IW)
  ) u_expand (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (exp_start),
    .key_i     (key_q),
    .wr_en_o   (exp_we),
    .wr_idx_o  (exp_idx),
    .wr_word_o (exp_word),
    .done_o    (exp_done)
  );

  aes_round u_round (
    .st_i    (blk_q),
    .rk_i    (rk_q),
    .dec_i   (dec_q),
    .first_i (rnd_q == '0),
    .last_i  (rnd_q == RW'(ROUNDS)),
    .st_o    (round_out)
  );

  assign rnd_nxt = rnd_q + RW'(1);

  always_comb begin
    state_d   = state_q;
    rnd_d     = rnd_q;
    stale_d   = stale_q;
    dec_d     = dec_q;
    blk_d     = blk_q;
    out_d     = out_q;
    outv_d    = outv_q;
    exp_start = 1'b0;
    rd_en     = 1'b0;
    rd_row    = '0;

    if (outv_q && out_ready_i) begin
      outv_d = 1'b0;
    end
    if (cfg_we_i) begin
      stale_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          blk_d = {block_upper_i, block_lower_i};
          dec_d = (opcode_i == OP_DECRYPT);
          if (stale_q) begin
            exp_start = 1'b1;
            stale_d   = 1'b0;
            state_d   = ST_EXPAND;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_EXPAND: begin
        if (exp_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rd_en   = 1'b1;
        rd_row  = dec_q ? RW'(ROUNDS) : '0;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        blk_d = round_out;
        rnd_d = rnd_nxt;
        if (rnd_q == RW'(ROUNDS)) begin
          state_d = ST_FINISH;
        end else begin
          rd_en  = 1'b1;
          rd_row = dec_q ? (RW'(ROUNDS) - rnd_nxt) : rnd_nxt;
        end
      end
      ST_FINISH: begin
        if (!outv_q || out_ready_i) begin
          out_d   = blk_q;
          outv_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      stale_q <= 1'b1;
      outv_q  <= 1'b0;
      key_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      stale_q <= stale_d;
      outv_q  <= outv_d;
      if (cfg_we_i) begin
        key_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
    blk_q <= blk_d;
    out_q <= out_d;
  end

  // round-key store: word i lives in row i/4, bank i%4
  always_ff @(posedge clk_i) begin
    if (exp_we) begin
      rk_mem[exp_idx[IW-1:2]][exp_idx[1:0]] <= exp_word;
    end
    if (rd_en) begin
      rk_q <= {rk_mem[rd_row][0], rk_mem[rd_row][1], rk_mem[rd_row][2], rk_mem[rd_row][3]};
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = outv_q;
  assign out_upper_o = out_q[127:64];
  assign out_lower_o = out_q[63:0];

endmodule

// ===== dv/tb_top.sv =====
// Testbench for aes_block_cipher: ECB encrypt/decrypt beats checked against an in-bench AES model.
// Depends on aes_pkg (state_t, op_e) and the aes_block_cipher RTL; reads no files.
// Covers the reset key, the published vector, key extremes and random traffic with and without handshake stalls.
module tb_top;
  import aes_pkg::*;

  localparam int KEY_WORDS = 4;
  localparam int ROUNDS    = 10;
  localparam int RK_WORDS  = 4 * (ROUNDS + 1);
  localparam int LATENCY   = ROUNDS + 3 + RK_WORDS;
  localparam int BURST_LEN = 28;
  localparam logic [7:0] REDUCE_POLY = 8'h1b;
  localparam int KEY_REG_LAST = 3;

  localparam logic [0:255][7:0] SUB_TABLE = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  typedef struct {
    logic [63:0] upper;
    logic [63:0] lower;
    op_e         op;
    int unsigned seq;
  } cipher_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        opcode_i;
  logic [63:0] block_upper_i;
  logic [63:0] block_lower_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] out_upper_o;
  logic [63:0] out_lower_o;

  // model state
  logic [63:0] key_regs [4];
  logic [31:0] rk_words [RK_WORDS];
  logic [7:0]  inv_sub_table [256];
  bit          sched_stale;

  cipher_result_t pending_blocks [$];
  int unsigned n_sent, n_checked, n_enc, n_dec, n_key_writes, n_errors;
  int unsigned send_idle_pct, recv_stall_pct;

  aes_block_cipher #(
    .KEY_WORDS(KEY_WORDS),
    .ROUNDS   (ROUNDS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .block_upper_i(block_upper_i),
    .block_lower_i(block_lower_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_upper_o  (out_upper_o),
    .out_lower_o  (out_lower_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- AES model
  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? REDUCE_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = gf_double(a);
    end
    return acc;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SUB_TABLE[w[31:24]], SUB_TABLE[w[23:16]], SUB_TABLE[w[15:8]], SUB_TABLE[w[7:0]]};
  endfunction

  function automatic void expand_key_schedule();
    logic [7:0]  rcon;
    logic [31:0] t;
    rcon = 8'h01;
    for (int i = 0; i < RK_WORDS; i++) begin
      if (i < KEY_WORDS) begin
        rk_words[i] = (i % 2) ? key_regs[(i >> 1) & 3][31:0] : key_regs[(i >> 1) & 3][63:32];
      end else begin
        t = rk_words[i - 1];
        if (i % KEY_WORDS == 0) begin
          t = sub_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
          rcon = gf_double(rcon);
        end else if (KEY_WORDS > 6 && i % KEY_WORDS == 4) begin
          t = sub_word(t);
        end
        rk_words[i] = rk_words[i - KEY_WORDS] ^ t;
      end
    end
    sched_stale = 1'b0;
  endfunction

  // byte 4*c+r is row r, column c
  function automatic state_t add_round_key(input state_t s, input int rnd);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = rk_words[rnd * 4 + c];
      s[4 * c + 0] ^= w[31:24];
      s[4 * c + 1] ^= w[23:16];
      s[4 * c + 2] ^= w[15:8];
      s[4 * c + 3] ^= w[7:0];
    end
    return s;
  endfunction

  function automatic state_t shift_state_rows(input state_t s, input bit inverse);
    state_t t;
    int src;
    t = s;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = inverse ? ((c - r + 4) & 3) : ((c + r) & 3);
        s[4 * c + r] = t[4 * src + r];
      end
    end
    return s;
  endfunction

  function automatic state_t mix_state_columns(input state_t s, input bit inverse);
    logic [7:0] m [4];
    logic [7:0] col [4];
    logic [7:0] acc;
    if (inverse) begin
      m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
    end else begin
      m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = s[4 * c + k];
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) acc ^= gf_mult(col[k], m[(k - r + 4) & 3]);
        s[4 * c + r] = acc;
      end
    end
    return s;
  endfunction

  function automatic state_t sub_state(input state_t s, input bit inverse);
    for (int k = 0; k < 16; k++) s[k] = inverse ? inv_sub_table[s[k]] : SUB_TABLE[s[k]];
    return s;
  endfunction

  function automatic state_t aes_transform(input op_e op, input state_t s);
    if (sched_stale) expand_key_schedule();
    if (op == OP_ENCRYPT) begin
      s = add_round_key(s, 0);
      for (int rnd = 1; rnd < ROUNDS; rnd++) begin
        s = add_round_key(mix_state_columns(shift_state_rows(sub_state(s, 0), 0), 0), rnd);
      end
      s = add_round_key(shift_state_rows(sub_state(s, 0), 0), ROUNDS);
    end else begin
      s = add_round_key(s, ROUNDS);
      for (int rnd = ROUNDS - 1; rnd > 0; rnd--) begin
        s = mix_state_columns(add_round_key(sub_state(shift_state_rows(s, 1), 1), rnd), 1);
      end
      s = add_round_key(sub_state(shift_state_rows(s, 1), 1), 0);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------- monitors
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      key_regs[cfg_idx_i] = cfg_data_i;
      sched_stale = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cipher_result_t r;
    logic [127:0] flat;
    if (rst_ni && in_valid_i && in_ready_o) begin
      r.op  = op_e'(opcode_i);
      flat  = aes_transform(r.op, {block_upper_i, block_lower_i});
      r.upper = flat[127:64];
      r.lower = flat[63:0];
      r.seq   = n_sent++;
      pending_blocks.push_back(r);
    end
  end

  always @(posedge clk_i) begin
    cipher_result_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_blocks.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result beat: upper %h lower %h", out_upper_o, out_lower_o);
      end else begin
        r = pending_blocks.pop_front();
        n_checked++;
        if (r.op == OP_ENCRYPT) n_enc++; else n_dec++;
        if (out_upper_o !== r.upper || out_lower_o !== r.lower) begin
          n_errors++;
          if (n_errors <= 10)
            $display("block %0d %s: upper exp %h got %h, lower exp %h got %h",
                     r.seq, r.op.name(), r.upper, out_upper_o, r.lower, out_lower_o);
        end
      end
    end
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // ---------------------------------------------------------------- drivers
  task automatic send_block(input op_e op, input logic [63:0] up, input logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    block_upper_i <= up;
    block_lower_i <= lo;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  // writes registers lo..hi back to back; call only when drained
  task automatic load_key_regs(input logic [63:0] vals [4], input int lo, input int hi);
    for (int i = lo; i <= hi; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[1:0];
      cfg_data_i <= vals[i];
      n_key_writes++;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] random_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return 64'haaaa_aaaa_aaaa_aaaa;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_reset_key();
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '1, '1);
    wait_drain();
  endtask

  task automatic test_known_answer();
    logic [63:0] k [4];
    logic [127:0] ct;
    k[0] = 64'h0001020304050607;
    k[1] = 64'h08090a0b0c0d0e0f;
    k[2] = 64'h1011121314151617;
    k[3] = 64'h18191a1b1c1d1e1f;
    load_key_regs(k, 0, KEY_REG_LAST);
    if (KEY_WORDS == 4) begin
      ct = aes_transform(OP_ENCRYPT, 128'h00112233445566778899aabbccddeeff);
      if (ct !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a) begin
        n_errors++;
        $display("model disagrees with the published AES-128 vector: %h", ct);
      end
    end
    send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(OP_DECRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    wait_drain();
  endtask

  task automatic test_key_extremes();
    logic [63:0] k [4];
    for (int i = 0; i < 4; i++) k[i] = '1;
    load_key_regs(k, 0, KEY_REG_LAST);
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '1, '1);
    send_block(OP_ENCRYPT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_block(OP_DECRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    wait_drain();
    // single low register rewrite, then a write to a register the key size ignores
    k[0] = '0;
    load_key_regs(k, 0, 0);
    send_block(OP_ENCRYPT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_block(OP_DECRYPT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    wait_drain();
    k[3] = 64'h0123_4567_89ab_cdef;
    load_key_regs(k, 3, 3);
    send_block(OP_ENCRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_block(OP_DECRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int unsigned send_pct [4] = '{0, 56, 0, 31};
    int unsigned recv_pct [4] = '{0, 0, 56, 31};
    logic [63:0] k [4];
    int idx;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      for (int i = 0; i < 4; i++) k[i] = random_word();
      load_key_regs(k, 0, KEY_REG_LAST);
      for (int b = 0; b < 4; b++) begin
        for (int n = 0; n < BURST_LEN; n++) begin
          send_block(op_e'($urandom_range(1)), random_word(), random_word());
        end
        // sender holds off until every result is back
        wait_drain();
        if ($urandom_range(1)) begin
          idx = $urandom_range(3);
          k[idx] = random_word();
          load_key_regs(k, idx, idx);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    for (int k = 0; k < 256; k++) inv_sub_table[SUB_TABLE[k]] = 8'(k);
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    sched_stale    = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_ENCRYPT;
    block_upper_i  = '0;
    block_lower_i  = '0;
    out_ready_i    = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_key();
    test_known_answer();
    test_key_extremes();
    test_random_traffic();

    wait_drain();
    if (pending_blocks.size() != 0) n_errors++;
    $display("%0d blocks checked (%0d encrypt, %0d decrypt), %0d key register writes, %0d errors",
             n_checked, n_enc, n_dec, n_key_writes, n_errors);
    $display("stall mixes: none, sender idle, receiver stall, both");
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/aes_pkg.sv
sv/aes_key_expand.sv
sv/aes_round.sv
sv/aes_block_cipher.sv
dv/tb_top.sv
